// ----- rtl/trc_pkg.sv -----
// shared types, coefficient tables and helpers for the thermocouple converter
package trc_pkg;

	typedef logic signed [63:0] s64_t;

	typedef enum logic [1:0] {
		SET_LO  = 2'd0,
		SET_HI  = 2'd1,
		SET_REV = 2'd2
	} set_t;

	typedef enum logic [3:0] {
		K_X0    = 4'd0,
		K_A     = 4'd1,
		K_C1    = 4'd2,
		K_C2    = 4'd3,
		K_C3    = 4'd4,
		K_C4    = 4'd5,
		K_D1    = 4'd6,
		K_D2    = 4'd7,
		K_D3    = 4'd8,
		K_ZERO  = 4'd9,
		K_ONE34 = 4'd10
	} kidx_t;

	typedef struct packed {
		logic valid;
		set_t set;
	} tag_t;

	localparam int QBITS    = 60;
	localparam int NS_SHIFT = 12;
	localparam int LOW_POS  = 48;
	localparam logic [63:0] QLIM   = 64'd1 << QBITS;
	localparam logic [63:0] QCLAMP = 64'd1 << 62;
	localparam logic [31:0] RES_POS_MAX = 32'd1048575;
	localparam logic [31:0] RES_NEG_MAX = 32'd1048576;
	localparam logic [31:0] BAND_LO = 32'd4096;
	localparam logic [31:0] BAND_HI = 32'd16397;

	// round_half_up(|m| * 2^f / 10^k) with sign of m, elaboration only
	function automatic s64_t scq(input longint m, input int k, input int f);
		logic [191:0] v;
		logic [191:0] r;
		logic [63:0] u;
		longint mg;
		mg = (m < 0) ? -m : m;
		v = 192'(mg) << f;
		r = '0;
		for (int i = 1; i < k; i++) begin
			v = v / 10;
		end
		if (k > 0) begin
			r = v % 10;
			v = v / 10;
		end
		u = v[63:0] + ((r >= 192'd5) ? 64'd1 : 64'd0);
		return (m < 0) ? -$signed(u) : $signed(u);
	endfunction

	localparam s64_t KQ_TAB [3][9] = '{
		'{scq(-34489914, 5, 24), scq(-87935962, 5, 32), scq(25678719, 9, 40),
		  scq(-49887904, 14, 60), scq(-44705222, 17, 82), scq(-44869203, 21, 100),
		  scq(23893439, 14, 55), scq(-20397750, 15, 76), scq(-18424107, 19, 96)},
		'{scq(12631386, 3, 24), scq(31018976, 3, 32), scq(24061949, 9, 40),
		  scq(40158622, 13, 60), scq(26853917, 17, 82), scq(-97188544, 22, 100),
		  scq(16995872, 11, 55), scq(11413069, 15, 76), scq(-39275155, 20, 96)},
		'{scq(25000000, 4, 24), scq(10003453, 4, 32), scq(40514854, 11, 40),
		  scq(-38789638, 16, 60), scq(-28608478, 19, 82), scq(-95367041, 25, 100),
		  scq(-13948675, 12, 55), scq(-67976627, 16, 76), scq(0, 1, 96)}
	};

	function automatic s64_t coef(input set_t s, input kidx_t k);
		s64_t c;
		c = '0;
		priority if (k == K_ZERO) begin
			c = '0;
		end else if (k == K_ONE34) begin
			c = $signed(64'd1 << 34);
		end else if (s == SET_LO || s == SET_HI || s == SET_REV) begin
			c = KQ_TAB[s][k];
		end else begin
			c = '0;
		end
		return c;
	endfunction

endpackage

// ----- rtl/trc_step.sv -----
// one horner step for numerator and denominator: split multiply, sum, round and add
module trc_step import trc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  tag_t        tag_in,
	input  s64_t        x_in,
	input  s64_t        h_in,
	input  s64_t        g_in,
	input  kidx_t       kh,
	input  kidx_t       kg,
	input  logic [6:0]  shh,
	input  logic [6:0]  shg,
	input  logic        g_hold,
	output tag_t        tag_out,
	output s64_t        x_out,
	output s64_t        h_out,
	output s64_t        g_out
);

	logic [63:0] ma, mh, mg;
	tag_t tag_s1, tag_s2, tag_s3;
	s64_t x_s1, x_s2, x_s3, g_s1, g_s2, h_s3, g_s3;
	logic [63:0] ph_s1 [4];
	logic [63:0] pg_s1 [4];
	logic negh_s1, negg_s1, negh_s2, negg_s2;
	logic [127:0] ph_s2, pg_s2;

	function automatic logic [127:0] psum(input logic [63:0] p0, input logic [63:0] p1,
		input logic [63:0] p2, input logic [63:0] p3);
		return {64'd0, p0} + ({64'd0, p1} << 32) + ({64'd0, p2} << 32) + {p3, 64'd0};
	endfunction

	function automatic s64_t shrnd(input logic [127:0] p, input logic [6:0] sh,
		input logic neg, input s64_t add);
		logic [127:0] a;
		logic [127:0] b;
		logic [63:0] u;
		a = p >> sh;
		b = p >> (sh - 7'd1);
		u = a[63:0] + {63'd0, b[0]};
		if (u > QCLAMP) begin
			u = QCLAMP;
		end
		return (neg ? -$signed(u) : $signed(u)) + add;
	endfunction

	assign ma = x_in[63] ? 64'(-x_in) : 64'(x_in);
	assign mh = h_in[63] ? 64'(-h_in) : 64'(h_in);
	assign mg = g_in[63] ? 64'(-g_in) : 64'(g_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (adv) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= x_in;
			g_s1 <= g_in;
			ph_s1[0] <= 64'(ma[31:0]) * 64'(mh[31:0]);
			ph_s1[1] <= 64'(ma[31:0]) * 64'(mh[63:32]);
			ph_s1[2] <= 64'(ma[63:32]) * 64'(mh[31:0]);
			ph_s1[3] <= 64'(ma[63:32]) * 64'(mh[63:32]);
			pg_s1[0] <= 64'(ma[31:0]) * 64'(mg[31:0]);
			pg_s1[1] <= 64'(ma[31:0]) * 64'(mg[63:32]);
			pg_s1[2] <= 64'(ma[63:32]) * 64'(mg[31:0]);
			pg_s1[3] <= 64'(ma[63:32]) * 64'(mg[63:32]);
			negh_s1 <= x_in[63] ^ h_in[63];
			negg_s1 <= x_in[63] ^ g_in[63];

			x_s2 <= x_s1;
			g_s2 <= g_s1;
			ph_s2 <= psum(ph_s1[0], ph_s1[1], ph_s1[2], ph_s1[3]);
			pg_s2 <= psum(pg_s1[0], pg_s1[1], pg_s1[2], pg_s1[3]);
			negh_s2 <= negh_s1;
			negg_s2 <= negg_s1;

			x_s3 <= x_s2;
			h_s3 <= shrnd(ph_s2, shh, negh_s2, coef(tag_s2.set, kh));
			g_s3 <= g_hold ? g_s2 : shrnd(pg_s2, shg, negg_s2, coef(tag_s2.set, kg));
		end
	end

	assign tag_out = tag_s3;
	assign x_out   = x_s3;
	assign h_out   = h_s3;
	assign g_out   = g_s3;

endmodule

// ----- rtl/trc_div.sv -----
// restoring divider, one quotient bit per pipeline stage
module trc_div import trc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  tag_t              tag_in,
	input  logic [63:0]       rem_in,
	input  logic [63:0]       d_in,
	input  logic [11:0]       low_in,
	input  logic              qsat_in,
	input  logic              neg_in,
	output tag_t              tag_out,
	output logic [QBITS-1:0]  q_out,
	output logic              qsat_out,
	output logic              neg_out
);

	tag_t tag_s [QBITS+1];
	logic [63:0] rem_s [QBITS+1];
	logic [63:0] d_s [QBITS+1];
	logic [11:0] low_s [QBITS+1];
	logic [QBITS-1:0] q_s [QBITS+1];
	logic qsat_s [QBITS+1];
	logic neg_s [QBITS+1];

	assign tag_s[0]  = tag_in;
	assign rem_s[0]  = rem_in;
	assign d_s[0]    = d_in;
	assign low_s[0]  = low_in;
	assign q_s[0]    = '0;
	assign qsat_s[0] = qsat_in;
	assign neg_s[0]  = neg_in;

	for (genvar i = 0; i < QBITS; i++) begin : g_bit
		localparam int BI = QBITS - 1 - i;
		logic bin;
		logic [64:0] t;
		logic [64:0] df;
		logic ge;

		if (BI >= LOW_POS) begin : g_low
			assign bin = low_s[i][BI-LOW_POS];
		end else begin : g_zero
			assign bin = 1'b0;
		end

		assign t  = {rem_s[i], bin};
		assign ge = t >= {1'b0, d_s[i]};
		assign df = t - {1'b0, d_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i+1] <= '0;
			end else if (adv) begin
				tag_s[i+1] <= tag_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1]  <= ge ? df[63:0] : t[63:0];
				d_s[i+1]    <= d_s[i];
				low_s[i+1]  <= low_s[i];
				q_s[i+1]    <= {q_s[i][QBITS-2:0], ge};
				qsat_s[i+1] <= qsat_s[i];
				neg_s[i+1]  <= neg_s[i];
			end
		end
	end

	assign tag_out  = tag_s[QBITS];
	assign q_out    = q_s[QBITS];
	assign qsat_out = qsat_s[QBITS];
	assign neg_out  = neg_s[QBITS];

endmodule

// ----- rtl/thermocouple_rational_convert.sv -----
// top level: rational polynomial conversion between thermocouple microvolts and 0.01 C
// One transaction enters per clock unless the pipeline holds, and passes through one input
// stage, four horner steps of three stages each (split 32x32 multiplies, partial sum,
// round and add), one divider setup stage, a 60-stage restoring divider that makes one
// quotient bit per stage, and two stages of offset add, rounding and clamping. The
// whole pipeline holds while a result waits on rsp_ready, so throughput stays at one
// transaction per cycle whenever the consumer keeps up.
module thermocouple_rational_convert import trc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic               req_type,
	input  logic signed [21:0] value,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic signed [20:0] result,
	output logic               band,
	output logic               saturated
);

	logic adv;
	logic band_hi;
	set_t set_in;
	s64_t x_in;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	s64_t x_s1;

	tag_t st_tag [5];
	s64_t st_x [5];
	s64_t st_h [5];
	s64_t st_g [5];

	logic [63:0] dmag, nmag;
	logic [73:0] ns;
	logic [9:0] scale;
	logic qsat_c, neg_c;
	logic [63:0] rem_s2, d_s2;
	logic [11:0] low_s2;
	logic qsat_s2, neg_s2;

	tag_t dv_tag;
	logic [QBITS-1:0] dv_q;
	logic dv_qsat, dv_neg;
	logic [63:0] qf;
	s64_t total_s3;

	logic [63:0] mag;
	logic [31:0] res;
	logic [20:0] result_s4;
	logic sat_s4;

	assign adv = !tag_s4.valid || rsp_ready;
	assign req_ready = adv;

	assign band_hi = !req_type && (value >= $signed(BAND_LO[21:0]))
		&& (value <= $signed(BAND_HI[21:0]));
	assign set_in = req_type ? SET_REV : (band_hi ? SET_HI : SET_LO);
	assign x_in = ($signed(64'(value)) <<< 24) - coef(set_in, K_X0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1 <= '{valid: req_valid, set: set_in};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= x_in;
		end
	end

	assign st_tag[0] = tag_s1;
	assign st_x[0]   = x_s1;
	assign st_h[0]   = coef(tag_s1.set, K_C4);
	assign st_g[0]   = coef(tag_s1.set, K_D3);

	trc_step u_step1 (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.tag_in(st_tag[0]), .x_in(st_x[0]), .h_in(st_h[0]), .g_in(st_g[0]),
		.kh(K_C3), .kg(K_D2), .shh(7'd42), .shg(7'd44), .g_hold(1'b0),
		.tag_out(st_tag[1]), .x_out(st_x[1]), .h_out(st_h[1]), .g_out(st_g[1])
	);

	trc_step u_step2 (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.tag_in(st_tag[1]), .x_in(st_x[1]), .h_in(st_h[1]), .g_in(st_g[1]),
		.kh(K_C2), .kg(K_D1), .shh(7'd46), .shg(7'd45), .g_hold(1'b0),
		.tag_out(st_tag[2]), .x_out(st_x[2]), .h_out(st_h[2]), .g_out(st_g[2])
	);

	trc_step u_step3 (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.tag_in(st_tag[2]), .x_in(st_x[2]), .h_in(st_h[2]), .g_in(st_g[2]),
		.kh(K_C1), .kg(K_ONE34), .shh(7'd44), .shg(7'd45), .g_hold(1'b0),
		.tag_out(st_tag[3]), .x_out(st_x[3]), .h_out(st_h[3]), .g_out(st_g[3])
	);

	// last step finishes the numerator, denominator just rides along
	trc_step u_step4 (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.tag_in(st_tag[3]), .x_in(st_x[3]), .h_in(st_h[3]), .g_in(st_g[3]),
		.kh(K_ZERO), .kg(K_ZERO), .shh(7'd46), .shg(7'd45), .g_hold(1'b1),
		.tag_out(st_tag[4]), .x_out(st_x[4]), .h_out(st_h[4]), .g_out(st_g[4])
	);

	assign dmag  = st_g[4][63] ? 64'(-st_g[4]) : 64'(st_g[4]);
	assign nmag  = st_h[4][63] ? 64'(-st_h[4]) : 64'(st_h[4]);
	assign scale = (st_tag[4].set == SET_REV) ? 10'd1000 : 10'd100;
	assign ns    = 74'(nmag) * 74'(scale);
	assign qsat_c = (dmag == 64'd0) || ({2'b00, ns} >= {dmag, 12'd0});
	assign neg_c  = (dmag == 64'd0) ? st_h[4][63] : (st_h[4][63] ^ st_g[4][63]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (adv) begin
			tag_s2 <= st_tag[4];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s2  <= 64'(ns >> NS_SHIFT);
			d_s2    <= dmag;
			low_s2  <= ns[11:0];
			qsat_s2 <= qsat_c;
			neg_s2  <= neg_c;
		end
	end

	trc_div u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.tag_in(tag_s2), .rem_in(rem_s2), .d_in(d_s2), .low_in(low_s2),
		.qsat_in(qsat_s2), .neg_in(neg_s2),
		.tag_out(dv_tag), .q_out(dv_q), .qsat_out(dv_qsat), .neg_out(dv_neg)
	);

	assign qf = dv_qsat ? QLIM : 64'(dv_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (adv) begin
			tag_s3 <= dv_tag;
			tag_s4 <= tag_s3;
		end
	end

	assign mag = total_s3[63] ? 64'(-total_s3) : 64'(total_s3);

	always_comb begin
		if (tag_s3.set == SET_REV) begin
			res = mag[63:32];
		end else begin
			res = 32'((mag + (64'd1 << 31)) >> 32);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			total_s3 <= coef(dv_tag.set, K_A) + (dv_neg ? -$signed(qf) : $signed(qf));
			if (total_s3[63]) begin
				sat_s4    <= res > RES_NEG_MAX;
				result_s4 <= (res > RES_NEG_MAX) ? 21'(-RES_NEG_MAX) : 21'(-res);
			end else begin
				sat_s4    <= res > RES_POS_MAX;
				result_s4 <= (res > RES_POS_MAX) ? RES_POS_MAX[20:0] : res[20:0];
			end
		end
	end

	assign rsp_valid = tag_s4.valid;
	assign result    = $signed(result_s4);
	assign band      = (tag_s4.set == SET_HI);
	assign saturated = sat_s4;

endmodule
